>>> rtl/htps_pkg.sv
// ----------------------------------------------------------------------------
// htps_pkg
// Shared types, constants and table functions for the hartley power block.
// ----------------------------------------------------------------------------
package htps_pkg;

  localparam int unsigned POINTS_DEF = 64;
  localparam int unsigned ADDR_MAX_W = 6;   // addresses for up to 64 points

  localparam logic signed [15:0] SQRT2_Q14 = 16'sd23170;
  localparam logic [42:0] POWER_MAX = 43'h7FF_FFFF_FFFF;
  localparam logic signed [23:0] COEF_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] COEF_MIN = -24'sh800000;

  // cos(2*pi*t/64) in q2.14, first quadrant
  localparam logic signed [15:0] QCOS [0:16] = '{
    16'sd16384, 16'sd16305, 16'sd16069, 16'sd15679, 16'sd15137, 16'sd14449,
    16'sd13623, 16'sd12665, 16'sd11585, 16'sd10394, 16'sd9102, 16'sd7723,
    16'sd6270, 16'sd4756, 16'sd3196, 16'sd1606, 16'sd0
  };

  typedef enum logic [1:0] {
    WR_SAMPLE,
    WR_KERNEL,
    WR_SUM,
    WR_DIFF
  } wr_src_t;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_KRD,
    ST_KCAP,
    ST_KMUL,
    ST_KWR,
    ST_BR0,
    ST_BR1,
    ST_BR2,
    ST_BR3,
    ST_BR4,
    ST_BR5,
    ST_SRD,
    ST_SSQ,
    ST_SOUT,
    ST_TRD,
    ST_TOUT
  } state_t;

  typedef struct packed {
    logic                  wr_en;
    logic                  wr_bank;
    logic [ADDR_MAX_W-1:0] wr_addr;
    wr_src_t               wr_src;
    logic [2:0]            kslot;
    logic                  rd_en;
    logic                  rd_bank;
    logic [ADDR_MAX_W-1:0] rd_addr_a;
    logic [ADDR_MAX_W-1:0] rd_addr_b;
    logic                  kcap;
    logic [1:0]            kcap_q;
    logic                  kmul;
    logic                  cap_eo;
    logic                  cap_prod;
    logic [5:0]            tw;
    logic                  cap_a;
    logic                  cap_sq;
    logic                  push;
    logic                  push_spec;
    logic                  bin_zero;
    logic [5:0]            push_index;
    logic                  push_last;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

  function automatic logic signed [15:0] cos64(input logic [5:0] t);
    logic signed [15:0] r;
    if (t <= 6'd16) begin
      r = QCOS[t[4:0]];
    end else if (t <= 6'd32) begin
      r = -QCOS[5'(7'd32 - 7'(t))];
    end else if (t <= 6'd48) begin
      r = -QCOS[5'(t - 6'd32)];
    end else begin
      r = QCOS[5'(7'd64 - 7'(t))];
    end
    return r;
  endfunction

  // place of sample j after the even/odd splits down to 8-point blocks
  function automatic logic [5:0] frame_pos(input logic [5:0] j, input int unsigned lg);
    logic [5:0] p;
    logic [5:0] m;
    int unsigned w;
    p = j;
    for (int lv = 0; lv < 3; lv++) begin
      w = lg - lv;
      if (w > 3) begin
        m = 6'((7'd1 << w) - 7'd1);
        p = (p & ~m) | ((p & m) >> 1) | (6'(p[0]) << (w - 1));
      end
    end
    return p;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [27:0] v);
    logic signed [23:0] r;
    if (v > 28'(COEF_MAX)) begin
      r = COEF_MAX;
    end else if (v < 28'(COEF_MIN)) begin
      r = COEF_MIN;
    end else begin
      r = 24'(v);
    end
    return r;
  endfunction

endpackage

>>> rtl/htps_datapath.sv
// ----------------------------------------------------------------------------
// htps_datapath
// Ping-pong frame banks, 8-point kernel, butterfly unit, power and result stage.
// ----------------------------------------------------------------------------
module htps_datapath import htps_pkg::*; #(
  parameter int unsigned POINTS = POINTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output status_t             status,
  input  logic signed [15:0]  sample,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [5:0]          bin_index,
  output logic signed [23:0]  coefficient,
  output logic [42:0]         bin_power,
  output logic                last_bin
);

  localparam int unsigned AW = $clog2(POINTS);

  logic signed [23:0] bank0 [POINTS];
  logic signed [23:0] bank1 [POINTS];

  logic signed [23:0] rda0, rda1, rdb0, rdb1;
  logic               rsel;
  logic signed [23:0] rdata_a, rdata_b;

  logic signed [23:0] kr [8];
  logic signed [26:0] bf_r, dh_r;
  logic signed [24:0] dbf, ddh;
  logic signed [40:0] pbf, pdh;
  logic signed [27:0] s0, s1, s2, s3, t0, t2;
  logic signed [27:0] kern_sum;

  logic signed [23:0] ev_r, od_r;
  logic signed [15:0] tw_c, tw_s;
  logic signed [39:0] pc, ps, pc_r, ps_r;
  logic signed [40:0] psum;
  logic signed [26:0] a_r;

  logic [23:0] ax, ay;
  logic [47:0] sqx, sqy;
  logic [46:0] sqx_r, sqy_r;
  logic [47:0] pw_sum, pw;
  logic [42:0] pw_sat;

  logic signed [23:0] wdata;

  // memory banks
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      if (cmd.wr_bank) begin
        bank1[cmd.wr_addr[AW-1:0]] <= wdata;
      end else begin
        bank0[cmd.wr_addr[AW-1:0]] <= wdata;
      end
    end
    if (cmd.rd_en) begin
      rda0 <= bank0[cmd.rd_addr_a[AW-1:0]];
      rda1 <= bank1[cmd.rd_addr_a[AW-1:0]];
      rdb0 <= bank0[cmd.rd_addr_b[AW-1:0]];
      rdb1 <= bank1[cmd.rd_addr_b[AW-1:0]];
      rsel <= cmd.rd_bank;
    end
  end

  assign rdata_a = rsel ? rda1 : rda0;
  assign rdata_b = rsel ? rdb1 : rdb0;

  // 8-point kernel
  assign dbf = 25'(kr[1]) - 25'(kr[5]);
  assign ddh = 25'(kr[3]) - 25'(kr[7]);
  assign pbf = dbf * SQRT2_Q14;
  assign pdh = ddh * SQRT2_Q14;

  assign s0 = 28'(kr[0]) + 28'(kr[2]) + 28'(kr[4]) + 28'(kr[6]);
  assign s1 = 28'(kr[0]) + 28'(kr[2]) - 28'(kr[4]) - 28'(kr[6]);
  assign s2 = 28'(kr[0]) - 28'(kr[2]) + 28'(kr[4]) - 28'(kr[6]);
  assign s3 = 28'(kr[0]) - 28'(kr[2]) - 28'(kr[4]) + 28'(kr[6]);
  assign t0 = 28'(kr[1]) + 28'(kr[3]) + 28'(kr[5]) + 28'(kr[7]);
  assign t2 = 28'(kr[1]) - 28'(kr[3]) + 28'(kr[5]) - 28'(kr[7]);

  always_comb begin
    case (cmd.kslot)
      3'd0:    kern_sum = s0 + t0;
      3'd1:    kern_sum = s1 + 28'(bf_r);
      3'd2:    kern_sum = s2 + t2;
      3'd3:    kern_sum = s3 + 28'(dh_r);
      3'd4:    kern_sum = s0 - t0;
      3'd5:    kern_sum = s1 - 28'(bf_r);
      3'd6:    kern_sum = s2 - t2;
      default: kern_sum = s3 - 28'(dh_r);
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.kcap) begin
      kr[{cmd.kcap_q, 1'b0}] <= rdata_a;
      kr[{cmd.kcap_q, 1'b1}] <= rdata_b;
    end
    if (cmd.kmul) begin
      bf_r <= 27'(pbf >>> 14);
      dh_r <= 27'(pdh >>> 14);
    end
  end

  // butterfly
  assign tw_c = cos64(cmd.tw);
  assign tw_s = cos64(cmd.tw + 6'd48);
  assign pc   = tw_c * od_r;
  assign ps   = tw_s * rdata_a;
  assign psum = 41'(pc_r) + 41'(ps_r);

  always_ff @(posedge clk) begin
    if (cmd.cap_eo) begin
      ev_r <= rdata_a;
      od_r <= rdata_b;
    end
    if (cmd.cap_prod) begin
      pc_r <= pc;
      ps_r <= ps;
    end
    if (cmd.cap_a) begin
      a_r <= 27'(psum >>> 14);
    end
  end

  // write data select
  always_comb begin
    case (cmd.wr_src)
      WR_SAMPLE: wdata = 24'(sample);
      WR_KERNEL: wdata = sat24(kern_sum);
      WR_SUM:    wdata = sat24(28'(ev_r) + 28'(a_r));
      default:   wdata = sat24(28'(ev_r) - 28'(a_r));
    endcase
  end

  // power
  assign ax  = rdata_a[23] ? 24'(-rdata_a) : 24'(rdata_a);
  assign ay  = rdata_b[23] ? 24'(-rdata_b) : 24'(rdata_b);
  assign sqx = ax * ax;
  assign sqy = ay * ay;

  always_ff @(posedge clk) begin
    if (cmd.cap_sq) begin
      sqx_r <= 47'(sqx);
      sqy_r <= 47'(sqy);
    end
  end

  assign pw_sum = 48'(sqx_r) + 48'(sqy_r);
  assign pw     = cmd.bin_zero ? 48'(sqx_r) : (pw_sum >> 1);
  assign pw_sat = (pw > 48'(POWER_MAX)) ? POWER_MAX : 43'(pw);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      bin_index   <= cmd.push_index;
      last_bin    <= cmd.push_last;
      coefficient <= cmd.push_spec ? 24'sd0 : rdata_a;
      bin_power   <= cmd.push_spec ? pw_sat : 43'd0;
    end
  end

  assign status.out_free = !out_valid || out_ready;

endmodule

>>> rtl/htps_ctrl.sv
// ----------------------------------------------------------------------------
// htps_ctrl
// Frame sequencer: load, kernel pass, combine passes and result emission.
// ----------------------------------------------------------------------------
module htps_ctrl import htps_pkg::*; #(
  parameter int unsigned POINTS = POINTS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    cfg_valid,
  output logic    cfg_ready,
  input  logic    spectrum_mode,
  input  status_t status,
  output cmd_t    cmd
);

  localparam int unsigned AW   = $clog2(POINTS);
  localparam logic [2:0]  LOG2 = 3'(AW);

  state_t state, state_next;

  logic          mode;
  logic          frame_mode;
  logic          src;
  logic [AW-1:0] cnt;
  logic [2:0]    sub;
  logic [AW-4:0] kblk;
  logic [AW-2:0] bfly;
  logic [2:0]    lvl;

  logic          accept;
  logic          load_last;
  logic          kblk_last;
  logic          bfly_last;
  logic          emit_last;

  logic [AW-1:0] kbase;
  logic [AW-1:0] b_ext, half, imask, sbase, bi;
  logic [AW-1:0] ev_addr, od_addr, orv_addr;
  logic [AW-1:0] mirror;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_LOAD);
  assign accept    = in_valid && in_ready;
  assign load_last = (cnt == AW'(POINTS - 1));
  assign kblk_last = (kblk == '1);
  assign bfly_last = (bfly == '1);
  assign emit_last = frame_mode ? (cnt == AW'(POINTS / 2 - 1)) : (cnt == AW'(POINTS - 1));

  assign kbase    = AW'(kblk) << 3;
  assign b_ext    = AW'(bfly);
  assign half     = AW'(1) << (lvl - 3'd1);
  assign imask    = half - AW'(1);
  assign sbase    = (b_ext >> (lvl - 3'd1)) << lvl;
  assign bi       = b_ext & imask;
  assign ev_addr  = sbase | bi;
  assign od_addr  = sbase | half | bi;
  assign orv_addr = sbase | half | ((half - bi) & imask);
  assign mirror   = AW'(0) - cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      mode <= spectrum_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      cnt        <= '0;
      sub        <= '0;
      kblk       <= '0;
      bfly       <= '0;
      lvl        <= 3'd4;
      src        <= 1'b0;
      frame_mode <= 1'b1;
    end else begin
      state <= state_next;
      case (state)
        ST_LOAD: begin
          if (accept) begin
            cnt <= load_last ? '0 : cnt + AW'(1);
            if (load_last) begin
              frame_mode <= mode;
              kblk       <= '0;
              sub        <= '0;
              src        <= 1'b0;
            end
          end
        end
        ST_KRD: begin
          sub <= (sub == 3'd3) ? 3'd0 : sub + 3'd1;
        end
        ST_KCAP, ST_KMUL: begin
          sub <= '0;
        end
        ST_KWR: begin
          sub <= sub + 3'd1;
          if (sub == 3'd7) begin
            kblk <= kblk + 1'b1;
            if (kblk_last) begin
              src  <= ~src;
              lvl  <= 3'd4;
              bfly <= '0;
            end
          end
        end
        ST_BR5: begin
          bfly <= bfly + 1'b1;
          if (bfly_last) begin
            src <= ~src;
            lvl <= lvl + 3'd1;
            cnt <= '0;
          end
        end
        ST_SOUT, ST_TOUT: begin
          if (status.out_free) begin
            cnt <= emit_last ? '0 : cnt + AW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: if (accept && load_last) state_next = ST_KRD;
      ST_KRD:  if (sub == 3'd3) state_next = ST_KCAP;
      ST_KCAP: state_next = ST_KMUL;
      ST_KMUL: state_next = ST_KWR;
      ST_KWR: begin
        if (sub == 3'd7) state_next = kblk_last ? ST_BR0 : ST_KRD;
      end
      ST_BR0: state_next = ST_BR1;
      ST_BR1: state_next = ST_BR2;
      ST_BR2: state_next = ST_BR3;
      ST_BR3: state_next = ST_BR4;
      ST_BR4: state_next = ST_BR5;
      ST_BR5: begin
        if (bfly_last && lvl == LOG2) begin
          state_next = frame_mode ? ST_SRD : ST_TRD;
        end else begin
          state_next = ST_BR0;
        end
      end
      ST_SRD: state_next = ST_SSQ;
      ST_SSQ: state_next = ST_SOUT;
      ST_SOUT: begin
        if (status.out_free) state_next = emit_last ? ST_LOAD : ST_SRD;
      end
      ST_TRD: state_next = ST_TOUT;
      ST_TOUT: begin
        if (status.out_free) state_next = emit_last ? ST_LOAD : ST_TRD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // commands
  always_comb begin
    cmd            = '0;
    cmd.wr_src     = WR_SAMPLE;
    cmd.wr_bank    = ~src;
    cmd.rd_bank    = src;
    cmd.push_index = 6'(cnt);
    cmd.push_last  = emit_last;
    cmd.push_spec  = frame_mode;
    cmd.bin_zero   = (cnt == '0);
    case (state)
      ST_LOAD: begin
        cmd.wr_en   = accept;
        cmd.wr_bank = 1'b0;
        cmd.wr_addr = frame_pos(6'(cnt), AW);
      end
      ST_KRD: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_addr_a = 6'(kbase | AW'({sub[1:0], 1'b0}));
        cmd.rd_addr_b = 6'(kbase | AW'({sub[1:0], 1'b1}));
        cmd.kcap      = (sub != 3'd0);
        cmd.kcap_q    = sub[1:0] - 2'd1;
      end
      ST_KCAP: begin
        cmd.kcap   = 1'b1;
        cmd.kcap_q = 2'd3;
      end
      ST_KMUL: begin
        cmd.kmul = 1'b1;
      end
      ST_KWR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_src  = WR_KERNEL;
        cmd.wr_addr = 6'(kbase | AW'(sub));
        cmd.kslot   = sub;
      end
      ST_BR0: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_addr_a = 6'(ev_addr);
        cmd.rd_addr_b = 6'(od_addr);
      end
      ST_BR1: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_addr_a = 6'(orv_addr);
        cmd.rd_addr_b = 6'(orv_addr);
        cmd.cap_eo    = 1'b1;
      end
      ST_BR2: begin
        cmd.cap_prod = 1'b1;
        cmd.tw       = 6'(6'(bi) << (3'd6 - lvl));
      end
      ST_BR3: begin
        cmd.cap_a = 1'b1;
      end
      ST_BR4: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_src  = WR_SUM;
        cmd.wr_addr = 6'(ev_addr);
      end
      ST_BR5: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_src  = WR_DIFF;
        cmd.wr_addr = 6'(od_addr);
      end
      ST_SRD, ST_TRD: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_addr_a = 6'(cnt);
        cmd.rd_addr_b = 6'(mirror);
      end
      ST_SSQ: begin
        cmd.cap_sq = 1'b1;
      end
      ST_SOUT, ST_TOUT: begin
        cmd.push = status.out_free;
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_bank_apart: assert property (@(posedge clk) disable iff (rst)
    (cmd.wr_en && cmd.rd_en) |-> (cmd.wr_bank != cmd.rd_bank))
    else $error("read and write hit the same bank");

  a_frame_start: assert property (@(posedge clk) disable iff (rst)
    (accept && load_last) |=> (state == ST_KRD && src == 1'b0))
    else $error("frame did not start the kernel pass");

  a_no_push_loading: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD) |-> !cmd.push)
    else $error("result pushed while loading");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BR0 || state == ST_BR5) |-> (lvl >= 3'd4 && lvl <= LOG2))
    else $error("combine level out of range");
`endif

endmodule

>>> rtl/hartley_transform_power_spectrum.sv
// ----------------------------------------------------------------------------
// hartley_transform_power_spectrum
// Radix-2 fast hartley transform of a sample frame with optional power output.
// ----------------------------------------------------------------------------
// samples are taken one per cycle while loading, POINTS of them to a frame, and
// written straight to their place after the even/odd splits. the last sample
// starts the transform: a pass of 8-point kernels over the frame, then
// log2(POINTS)-3 combine passes of POINTS/2 butterflies through a single
// butterfly unit, the data moving between two frame banks each pass. then
// results leave in order through an output register: POINTS coefficients, or
// POINTS/2 power bins, the sequencer waiting out any output stall. no sample
// is taken while a frame is being transformed or sent, but the next frame
// starts loading while the final result still waits.
// the mode register is sampled when the last sample of a frame is accepted.
module hartley_transform_power_spectrum import htps_pkg::*; #(
  parameter int unsigned POINTS = POINTS_DEF   // power of two, 16 to 64
) (
  input  logic               clk,
  input  logic               rst,
  // sample channel, one sample per transaction
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] sample,
  // mode register write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               spectrum_mode,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [5:0]         bin_index,
  output logic signed [23:0] coefficient,
  output logic [42:0]        bin_power,
  output logic               last_bin
);

  cmd_t    cmd;      // per-cycle commands to the datapath
  status_t status;   // result slot state back to the sequencer

  // sequencer: counters, addresses and mode
  htps_ctrl #(
    .POINTS (POINTS)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .spectrum_mode (spectrum_mode),
    .status        (status),
    .cmd           (cmd)
  );

  // banks, arithmetic and the output register
  htps_datapath #(
    .POINTS (POINTS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .sample      (sample),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .bin_index   (bin_index),
    .coefficient (coefficient),
    .bin_power   (bin_power),
    .last_bin    (last_bin)
  );

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Regression bench for the hartley transform / power spectrum block: frames of
// directed and random samples in both output modes, with results checked
// against an in-bench fixed-point hartley model through a small scoreboard.
// ----------------------------------------------------------------------------

class htps_scoreboard;
  typedef struct {
    bit [5:0]           idx;
    logic signed [23:0] coef;
    logic [42:0]        pw;
    bit                 last;
  } bin_t;

  bin_t   expected_bins[$];
  longint frame_buf[64];
  longint work_buf[64];
  int     twiddle[128];
  int     fill;
  bit     mode;
  int     errors;
  int     bins_seen;
  int     frames_done;

  // q2.14 cosine of 2*pi*t/64, built from the first-quadrant values
  function int cos_q14(int t);
    t = t & 63;
    if (t <= 16) return int'(htps_pkg::QCOS[t]);
    if (t <= 32) return -int'(htps_pkg::QCOS[32 - t]);
    if (t <= 48) return -int'(htps_pkg::QCOS[t - 32]);
    return int'(htps_pkg::QCOS[64 - t]);
  endfunction

  function new();
    for (int m = 0; m < 64; m++) begin
      twiddle[2*m]   = cos_q14(m);
      twiddle[2*m+1] = cos_q14(m + 48);
    end
    fill = 0;
    mode = 1'b1;
    errors = 0;
    bins_seen = 0;
    frames_done = 0;
  endfunction

  function longint clip24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  // arithmetic shift floors, as the block truncates toward minus infinity
  function longint floor14(longint v);
    return v >>> 14;
  endfunction

  function void base8(int k);
    longint a, b, c, d, e, f, g, h, bf, dh, s0, s1, s2, s3, t0, t2;
    a = frame_buf[k];   b = frame_buf[k+1]; c = frame_buf[k+2]; d = frame_buf[k+3];
    e = frame_buf[k+4]; f = frame_buf[k+5]; g = frame_buf[k+6]; h = frame_buf[k+7];
    bf = floor14((b - f) * 23170);
    dh = floor14((d - h) * 23170);
    s0 = a + c + e + g; s1 = a + c - e - g;
    s2 = a - c + e - g; s3 = a - c - e + g;
    t0 = b + d + f + h; t2 = b - d + f - h;
    frame_buf[k]   = clip24(s0 + t0);
    frame_buf[k+1] = clip24(s1 + bf);
    frame_buf[k+2] = clip24(s2 + t2);
    frame_buf[k+3] = clip24(s3 + dh);
    frame_buf[k+4] = clip24(s0 - t0);
    frame_buf[k+5] = clip24(s1 - bf);
    frame_buf[k+6] = clip24(s2 - t2);
    frame_buf[k+7] = clip24(s3 - dh);
  endfunction

  function void fht(int k, int n);
    int h, stp, ci;
    longint c, s, ev, od, orv, a;
    if (n <= 8) begin
      base8(k);
      return;
    end
    h = n / 2;
    for (int i = 0; i < h; i++) begin
      work_buf[i]     = frame_buf[k + 2*i];
      work_buf[h + i] = frame_buf[k + 2*i + 1];
    end
    for (int i = 0; i < n; i++) frame_buf[k + i] = work_buf[i];
    fht(k, h);
    fht(k + h, h);
    stp = 64 / h;
    for (int i = 0; i < h; i++) begin
      ci  = (i * stp) % 128;
      c   = twiddle[ci];
      s   = twiddle[(ci + 1) % 128];
      ev  = frame_buf[k + i];
      od  = frame_buf[k + h + i];
      orv = frame_buf[k + h + ((h - i) & (h - 1))];
      a   = floor14(c * od + s * orv);
      work_buf[i]     = clip24(ev + a);
      work_buf[h + i] = clip24(ev - a);
    end
    for (int i = 0; i < n; i++) frame_buf[k + i] = work_buf[i];
  endfunction

  // accepted sample transaction; the 64th sample produces the frame's bins
  function void note_sample(logic signed [15:0] smp);
    bin_t b;
    longint x, y;
    longint unsigned p;
    frame_buf[fill] = smp;
    fill++;
    if (fill < 64) return;
    fill = 0;
    frames_done++;
    fht(0, 64);
    if (mode) begin
      for (int i = 0; i < 32; i++) begin
        x = frame_buf[i] < 0 ? -frame_buf[i] : frame_buf[i];
        if (i == 0) begin
          p = x * x;
        end else begin
          y = frame_buf[64 - i] < 0 ? -frame_buf[64 - i] : frame_buf[64 - i];
          p = (x * x + y * y) >> 1;
        end
        if (p > 64'h7FF_FFFF_FFFF) p = 64'h7FF_FFFF_FFFF;
        b.idx = 6'(i); b.coef = '0; b.pw = p[42:0]; b.last = (i == 31);
        expected_bins.push_back(b);
      end
    end else begin
      for (int i = 0; i < 64; i++) begin
        b.idx = 6'(i); b.coef = frame_buf[i][23:0]; b.pw = '0; b.last = (i == 63);
        expected_bins.push_back(b);
      end
    end
  endfunction

  function void check_bin(bit [5:0] idx, logic signed [23:0] coef, logic [42:0] pw,
                          bit last);
    bin_t e;
    bins_seen++;
    if (expected_bins.size() == 0) begin
      $display("%0t: unexpected bin, index %0d coefficient %0d power %0d",
               $time, idx, coef, pw);
      errors++;
      return;
    end
    e = expected_bins.pop_front();
    if (idx !== e.idx) begin
      $display("%0t: bin_index expected %0d actual %0d", $time, e.idx, idx);
      errors++;
    end
    if (coef !== e.coef) begin
      $display("%0t: coefficient bin %0d expected %0d actual %0d", $time, e.idx, e.coef, coef);
      errors++;
    end
    if (pw !== e.pw) begin
      $display("%0t: bin_power bin %0d expected %0d actual %0d", $time, e.idx, e.pw, pw);
      errors++;
    end
    if (last !== e.last) begin
      $display("%0t: last_bin bin %0d expected %0b actual %0b", $time, e.idx, e.last, last);
      errors++;
    end
  endfunction
endclass

module tb;
  import htps_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 60;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic signed [15:0] sample;
  logic               cfg_valid;
  logic               cfg_ready;
  logic               spectrum_mode;
  logic               out_valid;
  logic               out_ready;
  logic [5:0]         bin_index;
  logic signed [23:0] coefficient;
  logic [42:0]        bin_power;
  logic               last_bin;

  htps_scoreboard spectrum_sb;
  int  cycles;
  bit  steady;       // no idling on either side while set
  int  mode_writes;

  hartley_transform_power_spectrum DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .sample(sample),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .spectrum_mode(spectrum_mode),
    .out_valid(out_valid), .out_ready(out_ready), .bin_index(bin_index),
    .coefficient(coefficient), .bin_power(bin_power), .last_bin(last_bin)
  );

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("hartley_transform_power_spectrum regression: fail");
      $finish;
    end
  end

  // result side: check each transaction, then pick the next ready, at random unless steady
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      spectrum_sb.check_bin(bin_index, coefficient, bin_power, last_bin);
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= 31);
    end
  end

  // one sample transaction; valid held high straight through back-to-back items
  task automatic push_sample(logic signed [15:0] smp);
    while (!steady && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= smp;
    do @(posedge clk); while (!in_ready);
    spectrum_sb.note_sample(smp);
  endtask

  // hold off until every expected bin is out and the block has settled
  task automatic drain_results();
    in_valid <= 1'b0;
    while (spectrum_sb.expected_bins.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(bit m);
    cfg_valid     <= 1'b1;
    spectrum_mode <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    spectrum_sb.mode = m;
    mode_writes++;
  endtask

  function automatic logic signed [15:0] pick_sample(int flavour, int j);
    case (flavour)
      0: pick_sample = 16'($urandom);
      1: pick_sample = 16'($signed($urandom_range(15)) - 8);
      2: pick_sample = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      default: pick_sample = (j % 8 < 4) ? 16'sh7FFF - 16'($urandom_range(255))
                                         : 16'sh8000 + 16'($urandom_range(255));
    endcase
  endfunction

  // modes per frame: spectrum after reset, then both settings, some repeated back to back
  bit frame_mode [7] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};

  initial begin
    logic signed [15:0] edge_vals [12];
    spectrum_sb   = new();
    steady        = 1'b0;
    mode_writes   = 0;
    rst           = 1'b1;
    in_valid      = 1'b0;
    sample        = '0;
    cfg_valid     = 1'b0;
    spectrum_mode = 1'b1;
    edge_vals = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh0001, 16'sh4000,
                  16'shC000, 16'sh5555, 16'shAAAA, 16'sh7FFF, 16'sh7FFF, 16'sh8000};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // frame 0 uses the reset mode; directed extremes lead it off
    for (int f = 0; f < 7; f++) begin
      if (f > 0) begin
        drain_results();
        write_mode(frame_mode[f]);
      end
      steady = (f == 4);
      for (int j = 0; j < 64; j++) begin
        case (f)
          0: push_sample(j < 12 ? edge_vals[j] : pick_sample(j < 24 ? 2 : 0, j));
          1: push_sample((j % 2) ? 16'sh8000 : 16'sh7FFF);
          2: push_sample(pick_sample(3, j));
          default: push_sample(pick_sample((f + j / 16) % 4 == 1 ? 1 :
                                           ($urandom_range(9) == 0 ? 2 : 0), j));
        endcase
      end
    end
    in_valid <= 1'b0;
    steady = 1'b0;
    while (spectrum_sb.expected_bins.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d frames, %0d bins checked, %0d mode writes",
             spectrum_sb.frames_done, spectrum_sb.bins_seen, mode_writes);
    $display("both output modes, full-scale and small samples, random stalls both sides");
    if (spectrum_sb.errors == 0 && spectrum_sb.expected_bins.size() == 0) begin
      $display("hartley_transform_power_spectrum regression: pass");
    end else begin
      $display("hartley_transform_power_spectrum regression: fail");
    end
    $finish;
  end
endmodule
